[design/kbt_pkg.sv]
// Shared types and constants for the keypad-set BCD countdown timer.
// No dependencies; imported by kbt_step and the top level.
package kbt_pkg;

  localparam int DIGIT_W = 4;
  localparam int CURSOR_W = 3;
  localparam int MODE_W = 2;
  localparam int KEY_W = 8;

  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'd42;
  localparam logic [KEY_W-1:0] KEY_LEFT = 8'd45;
  localparam logic [KEY_W-1:0] KEY_BACK = 8'd47;
  localparam logic [KEY_W-1:0] KEY_START = 8'd61;
  localparam logic [KEY_W-1:0] KEY_ZERO = 8'd48;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'd57;

  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;

  localparam logic [CURSOR_W-1:0] POS_MIN_TENS = 3'd0;
  localparam logic [CURSOR_W-1:0] POS_MIN_ONES = 3'd1;
  localparam logic [CURSOR_W-1:0] POS_COLON = 3'd2;
  localparam logic [CURSOR_W-1:0] POS_SEC_TENS = 3'd3;
  localparam logic [CURSOR_W-1:0] POS_SEC_ONES = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET = 2'd0,
    MODE_RUN = 2'd1,
    MODE_EXP = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] min_tens;
    logic [DIGIT_W-1:0] min_ones;
    logic [DIGIT_W-1:0] sec_tens;
    logic [DIGIT_W-1:0] sec_ones;
    logic [CURSOR_W-1:0] cursor;
    mode_t mode;
    logic blink;
  } timer_state_t;

endpackage

[design/keypad_set_bcd_countdown_timer.sv]
// MM:SS countdown timer set from a keypad, four BCD digits of state.
// Depends on kbt_pkg and kbt_step.
// Latency: the result for an item is valid the cycle after it is accepted.
// Throughput: one item per cycle unless stalled; state_r is the output reg.
// Reset: digits 00:00, cursor 0, setting mode, blink low, no result pending.
module keypad_set_bcd_countdown_timer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_req_type,
  input  logic [kbt_pkg::KEY_W-1:0] in_key_code,
  output logic out_valid,
  input  logic out_ready,
  output logic [kbt_pkg::DIGIT_W-1:0] out_minutes_tens,
  output logic [kbt_pkg::DIGIT_W-1:0] out_minutes_ones,
  output logic [kbt_pkg::DIGIT_W-1:0] out_seconds_tens,
  output logic [kbt_pkg::DIGIT_W-1:0] out_seconds_ones,
  output logic [kbt_pkg::CURSOR_W-1:0] out_cursor_pos,
  output logic [kbt_pkg::MODE_W-1:0] out_mode,
  output logic out_blink_led,
  output logic out_setting_led,
  output logic out_buzzer
);
  import kbt_pkg::*;

  timer_state_t state_r;
  timer_state_t state_nxt;
  logic out_valid_r;
  logic accept;

  kbt_step u_step (
    .cur    (state_r),
    .is_key (in_req_type),
    .key    (in_key_code),
    .nxt    (state_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{min_tens: '0, min_ones: '0, sec_tens: '0, sec_ones: '0,
                   cursor: POS_MIN_TENS, mode: MODE_SET, blink: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_minutes_tens = state_r.min_tens;
  assign out_minutes_ones = state_r.min_ones;
  assign out_seconds_tens = state_r.sec_tens;
  assign out_seconds_ones = state_r.sec_ones;
  assign out_cursor_pos = state_r.cursor;
  assign out_mode = state_r.mode;
  assign out_blink_led = state_r.blink;
  assign out_setting_led = (state_r.mode == MODE_SET);
  assign out_buzzer = (state_r.mode == MODE_EXP);

  a_cursor_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cursor != POS_COLON && state_r.cursor <= POS_SEC_ONES)
    else $error("cursor left legal positions");

  a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == MODE_EXP |->
      (state_r.min_tens | state_r.min_ones | state_r.sec_tens | state_r.sec_ones) == '0)
    else $error("expired with nonzero time");

  a_expired_dark: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode != MODE_RUN |-> !state_r.blink)
    else $error("blink high outside counting");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(state_r))
    else $error("state changed while item pending");

endmodule

[design/kbt_step.sv]
// Next-state logic of the timer for one tick or key item.
// Depends on kbt_pkg.
module kbt_step (
  input  kbt_pkg::timer_state_t cur,
  input  logic is_key,
  input  logic [kbt_pkg::KEY_W-1:0] key,
  output kbt_pkg::timer_state_t nxt
);
  import kbt_pkg::*;

  timer_state_t dec;
  logic cur_zero;
  logic dec_zero;
  logic [KEY_W-1:0] key_off;
  logic [DIGIT_W-1:0] key_digit;
  logic is_digit;
  logic [CURSOR_W-1:0] cur_inc;

  assign key_off = key - KEY_ZERO;
  assign key_digit = key_off[DIGIT_W-1:0];
  assign is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
  assign cur_inc = cur.cursor + 3'd1;
  assign cur_zero = (cur.min_tens | cur.min_ones | cur.sec_tens | cur.sec_ones) == '0;
  assign dec_zero = (dec.min_tens | dec.min_ones | dec.sec_tens | dec.sec_ones) == '0;

  always_comb begin
    dec = cur;
    if (cur.sec_ones != '0) begin
      dec.sec_ones = cur.sec_ones - 4'd1;
    end else if (cur.sec_tens != '0) begin
      dec.sec_tens = cur.sec_tens - 4'd1;
      dec.sec_ones = DIGIT_NINE;
    end else if (cur.min_ones != '0) begin
      dec.min_ones = cur.min_ones - 4'd1;
      dec.sec_tens = DIGIT_FIVE;
      dec.sec_ones = DIGIT_NINE;
    end else if (cur.min_tens != '0) begin
      dec.min_tens = cur.min_tens - 4'd1;
      dec.min_ones = DIGIT_NINE;
      dec.sec_tens = DIGIT_FIVE;
      dec.sec_ones = DIGIT_NINE;
    end
  end

  always_comb begin
    nxt = cur;
    case (cur.mode)
      MODE_SET: begin
        if (is_key) begin
          if (key == KEY_RIGHT) begin
            if (cur_inc == POS_COLON) begin
              nxt.cursor = POS_SEC_TENS;
            end else if (cur_inc > POS_SEC_ONES) begin
              nxt.cursor = POS_MIN_TENS;
            end else begin
              nxt.cursor = cur_inc;
            end
          end else if (key == KEY_LEFT) begin
            if (cur.cursor == POS_MIN_TENS || cur.cursor > POS_SEC_ONES) begin
              nxt.cursor = POS_SEC_ONES;
            end else if (cur.cursor == POS_SEC_TENS) begin
              nxt.cursor = POS_MIN_ONES;
            end else begin
              nxt.cursor = cur.cursor - 3'd1;
            end
          end else if (is_digit) begin
            case (cur.cursor)
              POS_MIN_TENS: nxt.min_tens = key_digit;
              POS_MIN_ONES: nxt.min_ones = key_digit;
              POS_SEC_TENS: nxt.sec_tens = key_digit;
              POS_SEC_ONES: nxt.sec_ones = key_digit;
              default: ;
            endcase
          end else if (key == KEY_START) begin
            nxt.blink = 1'b0;
            nxt.mode = cur_zero ? MODE_EXP : MODE_RUN;
          end
        end
      end
      MODE_RUN: begin
        if (!is_key) begin
          nxt = dec;
          if (dec_zero) begin
            nxt.mode = MODE_EXP;
            nxt.blink = 1'b0;
          end else begin
            nxt.blink = ~cur.blink;
          end
        end
      end
      MODE_EXP: begin
        if (is_key && key == KEY_BACK) begin
          nxt.mode = MODE_SET;
          nxt.blink = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
